FILE: hw/rtl/ddr_pkg.sv
`default_nettype none

package ddr_pkg;

    // Width of one PWM duty magnitude.
    localparam int DUTY_W = 8;

    // Mix scaling limits, in percent.
    localparam int PCT_LIMIT  = 100;
    localparam int TRIM_LIMIT = 20;

    // Fixed jog magnitude.
    localparam int JOG_LEVEL = 150;

    // Division by 100 as a multiply by 5243 / 2^19. It is exact for every
    // product below 43000, and no product here exceeds 25500.
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 2 * DUTY_W;
    localparam int RECIP_W     = PROD_W + 13;

    // APB address width: eight 32-bit registers.
    localparam int ADDR_W = 5;

    typedef enum logic [1:0] {
        KIND_MIX  = 2'd0,
        KIND_STOP = 2'd1,
        KIND_JOG  = 2'd2,
        KIND_TICK = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MUL_SCALE = 2'd0,
        MUL_SIDE  = 2'd1,
        MUL_TRIM  = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic                left_invert;
        logic                right_invert;
        logic [DUTY_W-1:0]   max_duty;
        logic [DUTY_W-1:0]   min_duty;
        logic [DUTY_W-1:0]   accel;
        logic signed [5:0]   trim;
        logic [DUTY_W-1:0]   accel_override;
        logic [15:0]         tick_period;
    } cfg_t;

    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_en;
        logic     lift;
        logic     stop;
        logic     jog;
        logic     tick;
        logic     ramp;
        logic     drive;
        logic     load_out;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/differential_drive_ramp.sv
// Two-wheel motor drive with a mixer and a slew-limited ramp.
// Command channel: cmd_valid / cmd_stall carry one transaction of kind mix,
// hard stop, jog or tick. A transaction is taken at a rising edge where
// cmd_valid is high and cmd_stall is low. Result channel: res_valid /
// res_stall return exactly one result transaction for every command.
// A mix runs three multiply and divide-by-100 passes through two multiplier
// lanes, then the lift; a tick runs the jog check, the ramp and the bridge
// drive; a hard stop or a jog runs its stop or jog step. Each command then
// loads its result in the final step and returns to idle, where the next
// command is taken; the sequencer handles one command at a time.
// When the receiver stalls, the result sits in the output register and the
// next command is still accepted and processed; its result waits in the
// final step until the held result is taken.
// Reset clears targets, current duties, the jog and the tick timestamp and
// loads the register defaults (max duty 200, min duty 60, accel 10, tick
// period 20). The user must write registers through the APB port only while
// idle; the block itself does not enforce this.
`default_nettype none

module differential_drive_ramp #(
    parameter int DECEL_MULTIPLIER = 2,
    parameter int JOG_TIME         = 2000
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ddr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic [1:0]                  kind,
    input  logic signed [7:0]           left_pct,
    input  logic signed [7:0]           right_pct,
    input  logic [7:0]                  speed_pct,
    input  logic                        jog_left,
    input  logic signed [1:0]           jog_dir,
    input  logic [31:0]                 now,

    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        left_fwd,
    output logic                        left_rev,
    output logic [ddr_pkg::DUTY_W-1:0]  left_duty,
    output logic                        right_fwd,
    output logic                        right_rev,
    output logic [ddr_pkg::DUTY_W-1:0]  right_duty,
    output logic                        drive_updated,
    output logic                        jog_timed_out
);
    import ddr_pkg::*;

    // Register map: register n sits at byte address 4*n.
    typedef enum logic [2:0] {
        REG_LEFT_INVERT    = 3'd0,
        REG_RIGHT_INVERT   = 3'd1,
        REG_MAX_DUTY       = 3'd2,
        REG_MIN_DUTY       = 3'd3,
        REG_ACCEL          = 3'd4,
        REG_TRIM           = 3'd5,
        REG_ACCEL_OVERRIDE = 3'd6,
        REG_TICK_PERIOD    = 3'd7
    } reg_idx_t;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_sel;
    logic     wr_en;
    cmd_t     cmd;

    // The APB port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_LEFT_INVERT:    cfg_next.left_invert    = pwdata[0];
                REG_RIGHT_INVERT:   cfg_next.right_invert   = pwdata[0];
                REG_MAX_DUTY:       cfg_next.max_duty       = pwdata[DUTY_W-1:0];
                REG_MIN_DUTY:       cfg_next.min_duty       = pwdata[DUTY_W-1:0];
                REG_ACCEL:          cfg_next.accel          = pwdata[DUTY_W-1:0];
                REG_TRIM:           cfg_next.trim           = pwdata[5:0];
                REG_ACCEL_OVERRIDE: cfg_next.accel_override = pwdata[DUTY_W-1:0];
                REG_TICK_PERIOD:    cfg_next.tick_period    = pwdata[15:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_invert    <= 1'b0;
            cfg_reg.right_invert   <= 1'b0;
            cfg_reg.max_duty       <= 8'd200;
            cfg_reg.min_duty       <= 8'd60;
            cfg_reg.accel          <= 8'd10;
            cfg_reg.trim           <= 6'sd0;
            cfg_reg.accel_override <= 8'd0;
            cfg_reg.tick_period    <= 16'd20;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back; the trim register returns sign-extended.
    always_comb
    begin
        unique case (reg_sel)
            REG_LEFT_INVERT:    prdata = 32'(cfg_reg.left_invert);
            REG_RIGHT_INVERT:   prdata = 32'(cfg_reg.right_invert);
            REG_MAX_DUTY:       prdata = 32'(cfg_reg.max_duty);
            REG_MIN_DUTY:       prdata = 32'(cfg_reg.min_duty);
            REG_ACCEL:          prdata = 32'(cfg_reg.accel);
            REG_TRIM:           prdata = {{26{cfg_reg.trim[5]}}, cfg_reg.trim};
            REG_ACCEL_OVERRIDE: prdata = 32'(cfg_reg.accel_override);
            REG_TICK_PERIOD:    prdata = 32'(cfg_reg.tick_period);
        endcase
    end

    // The sequencer walks each command through its steps and owns both
    // handshakes; the datapath holds all drive state and the output register.
    ddr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .kind      (kind),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd)
    );

    ddr_datapath #(
        .DECEL_MULTIPLIER (DECEL_MULTIPLIER),
        .JOG_TIME         (JOG_TIME)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg_reg),
        .left_pct      (left_pct),
        .right_pct     (right_pct),
        .speed_pct     (speed_pct),
        .jog_left      (jog_left),
        .jog_dir       (jog_dir),
        .now           (now),
        .left_fwd      (left_fwd),
        .left_rev      (left_rev),
        .left_duty     (left_duty),
        .right_fwd     (right_fwd),
        .right_rev     (right_rev),
        .right_duty    (right_duty),
        .drive_updated (drive_updated),
        .jog_timed_out (jog_timed_out)
    );

`ifndef SYNTHESIS
    // An accepted command keeps the sequencer busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("sequencer idle right after accepting a command");

    // A bridge is never driven both ways at once.
    a_bridge_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(left_fwd && left_rev) && !(right_fwd && right_rev))
        else $error("bridge driven forward and reverse together");

    // A result that did not rewrite the bridges carries no drive.
    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !drive_updated) |->
            (left_duty == '0) && (right_duty == '0) && !left_fwd && !left_rev &&
            !right_fwd && !right_rev)
        else $error("drive fields set in a result without an update");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ddr_ctrl.sv
`default_nettype none

module ddr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  logic [1:0]    kind,
    output logic          cmd_stall,
    output logic          res_valid,
    input  logic          res_stall,
    output ddr_pkg::cmd_t cmd
);
    import ddr_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'h0001,
        S_MUL0   = 14'h0002,
        S_DIV0   = 14'h0004,
        S_MUL1   = 14'h0008,
        S_DIV1   = 14'h0010,
        S_MUL2   = 14'h0020,
        S_DIV2   = 14'h0040,
        S_LIFT   = 14'h0080,
        S_STOP   = 14'h0100,
        S_JOG    = 14'h0200,
        S_TICK   = 14'h0400,
        S_RAMP   = 14'h0800,
        S_DRIVE  = 14'h1000,
        S_FINISH = 14'h2000
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_SCALE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (kind_t'(kind))
                        KIND_MIX:  state_next = S_MUL0;
                        KIND_STOP: state_next = S_STOP;
                        KIND_JOG:  state_next = S_JOG;
                        KIND_TICK: state_next = S_TICK;
                    endcase
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SCALE;
                state_next  = S_DIV0;
            end
            S_DIV0:
            begin
                cmd.div_en = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SIDE;
                state_next  = S_DIV1;
            end
            S_DIV1:
            begin
                cmd.div_en = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TRIM;
                state_next  = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div_en = 1'b1;
                state_next = S_LIFT;
            end
            S_LIFT:
            begin
                cmd.lift   = 1'b1;
                state_next = S_FINISH;
            end
            S_STOP:
            begin
                cmd.stop   = 1'b1;
                state_next = S_FINISH;
            end
            S_JOG:
            begin
                cmd.jog    = 1'b1;
                state_next = S_FINISH;
            end
            S_TICK:
            begin
                cmd.tick   = 1'b1;
                state_next = S_RAMP;
            end
            S_RAMP:
            begin
                cmd.ramp   = 1'b1;
                state_next = S_DRIVE;
            end
            S_DRIVE:
            begin
                cmd.drive  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // The output register is free once its old result is taken.
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign res_valid_next = (res_valid_reg && res_stall) || cmd.load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ddr_datapath.sv
`default_nettype none

module ddr_datapath #(
    parameter int DECEL_MULTIPLIER = 2,
    parameter int JOG_TIME         = 2000
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ddr_pkg::cmd_t               cmd,
    input  ddr_pkg::cfg_t               cfg,
    input  logic signed [7:0]           left_pct,
    input  logic signed [7:0]           right_pct,
    input  logic [7:0]                  speed_pct,
    input  logic                        jog_left,
    input  logic signed [1:0]           jog_dir,
    input  logic [31:0]                 now,
    output logic                        left_fwd,
    output logic                        left_rev,
    output logic [ddr_pkg::DUTY_W-1:0]  left_duty,
    output logic                        right_fwd,
    output logic                        right_rev,
    output logic [ddr_pkg::DUTY_W-1:0]  right_duty,
    output logic                        drive_updated,
    output logic                        jog_timed_out
);
    import ddr_pkg::*;

    localparam int SW     = DUTY_W + 1;
    localparam int DOWN_W = DUTY_W + $clog2(DECEL_MULTIPLIER + 1);
    localparam int RW     = ((DOWN_W > DUTY_W + 2) ? DOWN_W : DUTY_W + 2) + 2;
    localparam logic signed [SW-1:0] JOG_POS = SW'(JOG_LEVEL);

    typedef struct packed {
        logic              fwd;
        logic              rev;
        logic [DUTY_W-1:0] duty;
    } side_t;

    function automatic logic signed [SW-1:0] lift(
        input logic [DUTY_W-1:0] mag,
        input logic              neg,
        input logic [DUTY_W-1:0] lo,
        input logic [DUTY_W-1:0] hi
    );
        logic [DUTY_W-1:0] m;
        m = mag;
        if (m < lo)
            m = lo;
        if (m > hi)
            m = hi;
        if (mag == '0)
            return '0;
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [SW-1:0] ramp_step(
        input logic signed [SW-1:0] cur,
        input logic signed [SW-1:0] tgt,
        input logic [DOWN_W-1:0]    up,
        input logic [DOWN_W-1:0]    down
    );
        logic [SW-1:0]          cm;
        logic [SW-1:0]          tm;
        logic [DOWN_W-1:0]      st;
        logic signed [RW-1:0]   cur_w;
        logic signed [RW-1:0]   diff;
        logic signed [RW-1:0]   sst;
        cm    = cur[SW-1] ? $unsigned(-cur) : $unsigned(cur);
        tm    = tgt[SW-1] ? $unsigned(-tgt) : $unsigned(tgt);
        st    = (tm > cm) ? up : down;
        cur_w = RW'(cur);
        diff  = RW'(tgt) - cur_w;
        sst   = RW'($signed({1'b0, st}));
        if (diff >= -sst && diff <= sst)
            return tgt;
        if (diff > 0)
            return SW'(cur_w + sst);
        return SW'(cur_w - sst);
    endfunction

    function automatic side_t drive_side(
        input logic                 inv,
        input logic signed [SW-1:0] cur,
        input logic [DUTY_W-1:0]    hi
    );
        logic signed [SW-1:0] d;
        logic [SW-1:0]        mag;
        side_t                s;
        d      = inv ? -cur : cur;
        s.fwd  = (d > 0);
        s.rev  = d[SW-1];
        mag    = d[SW-1] ? $unsigned(-d) : $unsigned(d);
        s.duty = (mag > {1'b0, hi}) ? hi : mag[DUTY_W-1:0];
        return s;
    endfunction

    // Captured transaction fields.
    logic [6:0]          lmag_reg, lmag_next, rmag_reg, rmag_next, sp_reg, sp_next;
    logic                lneg_reg, lneg_next, rneg_reg, rneg_next;
    logic                jleft_reg, jleft_next;
    logic signed [1:0]   jdir_reg, jdir_next;
    logic [31:0]         now_reg, now_next;

    // Two multiply lanes, each followed by a reciprocal divide by 100.
    logic [PROD_W-1:0]   prod_l_reg, prod_l_next, prod_r_reg, prod_r_next;
    logic [DUTY_W-1:0]   q_l_reg, q_l_next, q_r_reg, q_r_next;

    // Drive state.
    logic signed [SW-1:0] tl_reg, tl_next, tr_reg, tr_next;
    logic signed [SW-1:0] cl_reg, cl_next, cr_reg, cr_next;
    logic                 jog_active_reg, jog_active_next;
    logic [31:0]          deadline_reg, deadline_next;
    logic [31:0]          last_reg, last_next;
    logic                 due_reg, due_next;

    // Result staging and the output register.
    side_t rs_left_reg, rs_left_next, rs_right_reg, rs_right_next;
    logic  rs_upd_reg, rs_upd_next, rs_to_reg, rs_to_next;
    side_t out_left_reg, out_left_next, out_right_reg, out_right_next;
    logic  out_upd_reg, out_upd_next, out_to_reg, out_to_next;

    logic signed [7:0]   lp_c, rp_c;
    logic signed [5:0]   trim_s, tcl;
    logic [4:0]          tmag;
    logic [DUTY_W-1:0]   fl, fr;
    logic [DUTY_W-1:0]   a_l, b_l, a_r, b_r;
    logic [RECIP_W-1:0]  recip_l, recip_r;
    logic [DUTY_W-1:0]   up8;
    logic [DOWN_W-1:0]   up_c, down_c;
    logic [31:0]         jog_gap, elapsed;
    logic signed [SW-1:0] jog_target;

    always_comb
    begin
        // Percent clamps.
        if (left_pct > 8'sd100)
            lp_c = 8'sd100;
        else if (left_pct < -8'sd100)
            lp_c = -8'sd100;
        else
            lp_c = left_pct;
        if (right_pct > 8'sd100)
            rp_c = 8'sd100;
        else if (right_pct < -8'sd100)
            rp_c = -8'sd100;
        else
            rp_c = right_pct;

        // Trim clamp and the two side factors.
        trim_s = cfg.trim;
        if (trim_s > 6'sd20)
            tcl = 6'sd20;
        else if (trim_s < -6'sd20)
            tcl = -6'sd20;
        else
            tcl = trim_s;
        tmag = tcl[5] ? 5'(-tcl) : 5'(tcl);
        fl   = (tcl > 0) ? DUTY_W'(PCT_LIMIT) - DUTY_W'(tmag) : DUTY_W'(PCT_LIMIT);
        fr   = tcl[5] ? DUTY_W'(PCT_LIMIT) - DUTY_W'(tmag) : DUTY_W'(PCT_LIMIT);

        // Ramp steps.
        up8 = (cfg.accel_override != '0) ? cfg.accel_override : cfg.accel;
        if (up8 == '0)
            up8 = DUTY_W'(1);
        up_c   = DOWN_W'(up8);
        down_c = DOWN_W'(up8) * DOWN_W'(DECEL_MULTIPLIER);

        jog_gap = now_reg - deadline_reg;
        elapsed = now_reg - last_reg;

        if (jdir_reg[1])
            jog_target = -JOG_POS;
        else if (jdir_reg[0])
            jog_target = JOG_POS;
        else
            jog_target = '0;
    end

    // Multiplier operand selection.
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_SCALE:
            begin
                a_l = cfg.max_duty;
                b_l = {1'b0, sp_reg};
                a_r = cfg.max_duty;
                b_r = {1'b0, sp_reg};
            end
            MUL_SIDE:
            begin
                a_l = {1'b0, lmag_reg};
                b_l = q_l_reg;
                a_r = {1'b0, rmag_reg};
                b_r = q_l_reg;
            end
            MUL_TRIM:
            begin
                a_l = q_l_reg;
                b_l = fl;
                a_r = q_r_reg;
                b_r = fr;
            end
            default:
            begin
                a_l = '0;
                b_l = '0;
                a_r = '0;
                b_r = '0;
            end
        endcase
    end

    assign recip_l = RECIP_W'(prod_l_reg) * RECIP_W'(RECIP_100);
    assign recip_r = RECIP_W'(prod_r_reg) * RECIP_W'(RECIP_100);

    always_comb
    begin
        lmag_next       = lmag_reg;
        rmag_next       = rmag_reg;
        lneg_next       = lneg_reg;
        rneg_next       = rneg_reg;
        sp_next         = sp_reg;
        jleft_next      = jleft_reg;
        jdir_next       = jdir_reg;
        now_next        = now_reg;
        prod_l_next     = prod_l_reg;
        prod_r_next     = prod_r_reg;
        q_l_next        = q_l_reg;
        q_r_next        = q_r_reg;
        tl_next         = tl_reg;
        tr_next         = tr_reg;
        cl_next         = cl_reg;
        cr_next         = cr_reg;
        jog_active_next = jog_active_reg;
        deadline_next   = deadline_reg;
        last_next       = last_reg;
        due_next        = due_reg;
        rs_left_next    = rs_left_reg;
        rs_right_next   = rs_right_reg;
        rs_upd_next     = rs_upd_reg;
        rs_to_next      = rs_to_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_upd_next    = out_upd_reg;
        out_to_next     = out_to_reg;

        if (cmd.capture)
        begin
            lneg_next     = lp_c[7];
            rneg_next     = rp_c[7];
            lmag_next     = lp_c[7] ? 7'(-lp_c) : 7'(lp_c);
            rmag_next     = rp_c[7] ? 7'(-rp_c) : 7'(rp_c);
            sp_next       = (speed_pct > 8'(PCT_LIMIT)) ? 7'(PCT_LIMIT) : speed_pct[6:0];
            jleft_next    = jog_left;
            jdir_next     = jog_dir;
            now_next      = now;
            rs_left_next  = '0;
            rs_right_next = '0;
            rs_upd_next   = 1'b0;
            rs_to_next    = 1'b0;
        end

        if (cmd.mul_en)
        begin
            prod_l_next = {{DUTY_W{1'b0}}, a_l} * {{DUTY_W{1'b0}}, b_l};
            prod_r_next = {{DUTY_W{1'b0}}, a_r} * {{DUTY_W{1'b0}}, b_r};
        end

        if (cmd.div_en)
        begin
            q_l_next = recip_l[RECIP_SHIFT +: DUTY_W];
            q_r_next = recip_r[RECIP_SHIFT +: DUTY_W];
        end

        if (cmd.lift)
        begin
            tl_next         = lift(q_l_reg, lneg_reg, cfg.min_duty, cfg.max_duty);
            tr_next         = lift(q_r_reg, rneg_reg, cfg.min_duty, cfg.max_duty);
            jog_active_next = 1'b0;
            deadline_next   = '0;
        end

        if (cmd.stop)
        begin
            tl_next         = '0;
            tr_next         = '0;
            cl_next         = '0;
            cr_next         = '0;
            jog_active_next = 1'b0;
            deadline_next   = '0;
            rs_upd_next     = 1'b1;
        end

        if (cmd.jog)
        begin
            tl_next         = jleft_reg ? jog_target : '0;
            tr_next         = jleft_reg ? '0 : jog_target;
            jog_active_next = (jog_target != '0);
            deadline_next   = (jog_target != '0) ? now_reg + 32'(JOG_TIME) : '0;
        end

        if (cmd.tick)
        begin
            if (jog_active_reg && !jog_gap[31])
            begin
                jog_active_next = 1'b0;
                deadline_next   = '0;
                tl_next         = '0;
                tr_next         = '0;
                rs_to_next      = 1'b1;
            end
            due_next = (elapsed >= 32'(cfg.tick_period));
            if (elapsed >= 32'(cfg.tick_period))
                last_next = now_reg;
        end

        if (cmd.ramp && due_reg)
        begin
            cl_next = ramp_step(cl_reg, tl_reg, up_c, down_c);
            cr_next = ramp_step(cr_reg, tr_reg, up_c, down_c);
        end

        if (cmd.drive && due_reg)
        begin
            rs_left_next  = drive_side(cfg.left_invert, cl_reg, cfg.max_duty);
            rs_right_next = drive_side(cfg.right_invert, cr_reg, cfg.max_duty);
            rs_upd_next   = 1'b1;
        end

        if (cmd.load_out)
        begin
            out_left_next  = rs_left_reg;
            out_right_next = rs_right_reg;
            out_upd_next   = rs_upd_reg;
            out_to_next    = rs_to_reg;
        end
    end

    // Drive state other than the tick-due flag follows the reset of the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_reg         <= '0;
            tr_reg         <= '0;
            cl_reg         <= '0;
            cr_reg         <= '0;
            jog_active_reg <= 1'b0;
            deadline_reg   <= '0;
            last_reg       <= '0;
        end
        else
        begin
            tl_reg         <= tl_next;
            tr_reg         <= tr_next;
            cl_reg         <= cl_next;
            cr_reg         <= cr_next;
            jog_active_reg <= jog_active_next;
            deadline_reg   <= deadline_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lmag_reg      <= lmag_next;
        rmag_reg      <= rmag_next;
        lneg_reg      <= lneg_next;
        rneg_reg      <= rneg_next;
        sp_reg        <= sp_next;
        jleft_reg     <= jleft_next;
        jdir_reg      <= jdir_next;
        now_reg       <= now_next;
        prod_l_reg    <= prod_l_next;
        prod_r_reg    <= prod_r_next;
        q_l_reg       <= q_l_next;
        q_r_reg       <= q_r_next;
        due_reg       <= due_next;
        rs_left_reg   <= rs_left_next;
        rs_right_reg  <= rs_right_next;
        rs_upd_reg    <= rs_upd_next;
        rs_to_reg     <= rs_to_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_upd_reg   <= out_upd_next;
        out_to_reg    <= out_to_next;
    end

    assign left_fwd      = out_left_reg.fwd;
    assign left_rev      = out_left_reg.rev;
    assign left_duty     = out_left_reg.duty;
    assign right_fwd     = out_right_reg.fwd;
    assign right_rev     = out_right_reg.rev;
    assign right_duty    = out_right_reg.duty;
    assign drive_updated = out_upd_reg;
    assign jog_timed_out = out_to_reg;

endmodule

`default_nettype wire
